// ----- rtl/uart_rx_delimited_frame_unit_assert.svh -----
// Assertion macros for the receiver RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UART_RX_DELIMITED_FRAME_UNIT_ASSERT_SVH
`define UART_RX_DELIMITED_FRAME_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define URDF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define URDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define URDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/urdf_pkg.sv -----
`default_nettype none

package urdf_pkg;

  // Receiver phase codes.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BIT_TICKS   = 3'd0;
  localparam logic [2:0] CFG_FIRST_TICKS = 3'd1;
  localparam logic [2:0] CFG_START_BYTE  = 3'd2;
  localparam logic [2:0] CFG_END1_BYTE   = 3'd3;
  localparam logic [2:0] CFG_END2_BYTE   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] BIT_TICKS_RST   = 16'd52;
  localparam logic [15:0] FIRST_TICKS_RST = 16'd57;
  localparam logic [7:0]  START_BYTE_RST  = 8'h41;
  localparam logic [7:0]  END1_BYTE_RST   = 8'h0D;
  localparam logic [7:0]  END2_BYTE_RST   = 8'h0A;

  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [15:0] first_ticks;
    logic [7:0]  start_byte;
    logic [7:0]  end1_byte;
    logic [7:0]  end2_byte;
  } cfg_t;

  // A byte finished by the line receiver.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_t;

  // One result of the framer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [5:0] index;
    logic       last;
    logic       ovf;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/urdf_bit_rx.sv -----
`default_nettype none

// Line sampler: start detection, eight data bits LSB first, one stop bit time.
module urdf_bit_rx (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step_i,
  input  wire                 level_i,
  input  wire urdf_pkg::cfg_t cfg_i,
  output urdf_pkg::byte_t     byte_o
);

  urdf_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [3:0]       bits_r, bits_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [3:0]       bits_inc;
  logic             cnt_expired;
  logic             done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urdf_pkg::PH_IDLE;
      cnt_r   <= '0;
      bits_r  <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
    end
  end

  // A count of zero behaves as one.
  assign cnt_expired = (cnt_r <= 16'd1);
  assign bits_inc    = bits_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    done      = 1'b0;
    if (step_i) begin
      unique case (phase_r)
        urdf_pkg::PH_DATA: begin
          if (cnt_expired) begin
            shift_nxt = {level_i, shift_r[7:1]};
            bits_nxt  = bits_inc;
            cnt_nxt   = cfg_i.bit_ticks;
            if (bits_inc >= urdf_pkg::BITS_PER_BYTE) begin
              phase_nxt = urdf_pkg::PH_STOP;
            end
          end else begin
            cnt_nxt = cnt_r - 16'd1;
          end
        end
        urdf_pkg::PH_STOP: begin
          if (cnt_expired) begin
            phase_nxt = urdf_pkg::PH_IDLE;
            cnt_nxt   = '0;
            bits_nxt  = '0;
            done      = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 16'd1;
          end
        end
        default: begin
          phase_nxt = urdf_pkg::PH_IDLE;
          if (!level_i) begin
            phase_nxt = urdf_pkg::PH_DATA;
            cnt_nxt   = cfg_i.first_ticks;
            bits_nxt  = '0;
          end
        end
      endcase
    end
  end

  assign byte_o.vld  = done;
  assign byte_o.data = shift_r;

endmodule

`default_nettype wire

// ----- rtl/urdf_framer.sv -----
`default_nettype none

// Frame tracking: start hunt, end markers, byte index and overflow.
module urdf_framer #(
  parameter int MAX_FRAME = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire urdf_pkg::byte_t byte_i,
  input  wire urdf_pkg::cfg_t  cfg_i,
  output urdf_pkg::res_t       res_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_FRAME);
  localparam logic [CntW-1:0] LastIdx = CntW'(MAX_FRAME - 1);

  logic            in_frame_r, in_frame_nxt;
  logic            end1_seen_r, end1_seen_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            held;
  logic [CntW-1:0] idx;
  urdf_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      end1_seen_r <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      end1_seen_r <= end1_seen_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  assign held = (count_r < FullCnt);
  assign idx  = held ? count_r : LastIdx;

  always_comb begin
    in_frame_nxt  = in_frame_r;
    end1_seen_nxt = end1_seen_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    res.vld       = 1'b0;
    res.data      = byte_i.data;
    res.index     = 6'(idx);
    res.last      = 1'b0;
    res.ovf       = 1'b0;
    if (byte_i.vld) begin
      if (!in_frame_r) begin
        if (byte_i.data == cfg_i.start_byte) begin
          in_frame_nxt  = 1'b1;
          end1_seen_nxt = 1'b0;
          ovf_nxt       = 1'b0;
          count_nxt     = CntW'(1);
          res.vld       = 1'b1;
          res.index     = '0;
        end
      end else begin
        if (held) begin
          count_nxt = count_r + CntW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        res.vld = held;
        priority if (byte_i.data == cfg_i.end1_byte && !end1_seen_r) begin
          end1_seen_nxt = 1'b1;
        end else if (byte_i.data == cfg_i.end2_byte) begin
          res.vld       = 1'b1;
          res.last      = 1'b1;
          res.ovf       = ovf_r | ~held;
          in_frame_nxt  = 1'b0;
          end1_seen_nxt = 1'b0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end else begin
          // An ordinary data byte changes no marker state.
        end
      end
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ----- rtl/urdf_out_buf.sv -----
`default_nettype none

// Result register with a skid entry behind it.
module urdf_out_buf (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire urdf_pkg::res_t push_i,
  input  wire                 out_stall,
  output logic                out_valid,
  output urdf_pkg::res_t      out_o,
  output logic                full_o
);

  logic           out_vld_r, out_vld_nxt;
  logic           skid_vld_r, skid_vld_nxt;
  urdf_pkg::res_t out_r, out_nxt;
  urdf_pkg::res_t skid_r, skid_nxt;
  logic           out_free;

  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push_i.vld;
        out_nxt     = push_i;
      end
    end else if (push_i.vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_o     = out_r;
  assign full_o    = skid_vld_r;

`include "uart_rx_delimited_frame_unit_assert.svh"

  `URDF_ASSERT_ALWAYS(a_skid_behind_out, !skid_vld_r || out_vld_r, "skid holds data while output empty")
  `URDF_ASSERT_SAME(a_no_push_when_full, skid_vld_r, !push_i.vld, "result pushed into a full buffer")
  `URDF_ASSERT_NEXT(a_skid_drains, skid_vld_r && !out_stall, !skid_vld_r, "skid entry not moved forward")

endmodule

`default_nettype wire

// ----- rtl/uart_rx_delimited_frame_unit.sv -----
// A result is captured in the result register (or the skid entry, if the output is stalled)
// on the transfer of the line sample that completes its byte (the end of the stop bit time).
// Throughput: one line sample per cycle; the input stalls only when two results are held
// back by a stalled output (result register plus one skid entry).
// Reset: synchronous, active low; receiver idle, frame hunt rearmed, configuration back to
// its default values, no result pending.
`default_nettype none

module uart_rx_delimited_frame_unit #(
  parameter int MAX_FRAME = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  // Line samples, one per tick.
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_rx_level,
  // Frame bytes.
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last,
  output logic       out_overflow,
  // Configuration writes.
  input  wire        cfg_we,
  input  wire [2:0]  cfg_idx,
  input  wire [15:0] cfg_wdata
);

  // Configuration registers. Writes are only expected while the receiver is idle, so no
  // shadowing is needed. Indexes beyond the register list are ignored.
  logic [15:0]     bit_ticks_r;
  logic [15:0]     first_ticks_r;
  logic [7:0]      start_byte_r;
  logic [7:0]      end1_byte_r;
  logic [7:0]      end2_byte_r;
  urdf_pkg::cfg_t  cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r   <= urdf_pkg::BIT_TICKS_RST;
      first_ticks_r <= urdf_pkg::FIRST_TICKS_RST;
      start_byte_r  <= urdf_pkg::START_BYTE_RST;
      end1_byte_r   <= urdf_pkg::END1_BYTE_RST;
      end2_byte_r   <= urdf_pkg::END2_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        urdf_pkg::CFG_BIT_TICKS:   bit_ticks_r   <= cfg_wdata;
        urdf_pkg::CFG_FIRST_TICKS: first_ticks_r <= cfg_wdata;
        urdf_pkg::CFG_START_BYTE:  start_byte_r  <= cfg_wdata[7:0];
        urdf_pkg::CFG_END1_BYTE:   end1_byte_r   <= cfg_wdata[7:0];
        urdf_pkg::CFG_END2_BYTE:   end2_byte_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.bit_ticks   = bit_ticks_r;
  assign cfg.first_ticks = first_ticks_r;
  assign cfg.start_byte  = start_byte_r;
  assign cfg.end1_byte   = end1_byte_r;
  assign cfg.end2_byte   = end2_byte_r;

  // A sample transfer advances the whole datapath by one tick. The line sampler and the
  // framer update their state in the same cycle, so a finished byte reaches the framer
  // combinationally and its result is captured in the output buffer at that edge.
  logic            step;
  logic            buf_full;
  urdf_pkg::byte_t rx_byte;
  urdf_pkg::res_t  res;
  urdf_pkg::res_t  out_res;

  // The stall comes from a register: the input only waits when the skid entry is taken.
  assign in_stall = buf_full;
  assign step     = in_valid && !buf_full;

  urdf_bit_rx u_bit_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .level_i (in_rx_level),
    .cfg_i   (cfg),
    .byte_o  (rx_byte)
  );

  urdf_framer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_framer (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (rx_byte),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Output register plus skid entry, so that a result waiting on a stalled output does not
  // hold up the sample stream until a second result needs room.
  urdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_o     (out_res),
    .full_o    (buf_full)
  );

  assign out_data_byte  = out_res.data;
  assign out_byte_index = out_res.index;
  assign out_last       = out_res.last;
  assign out_overflow   = out_res.ovf;

endmodule

`default_nettype wire
